>>> sv/dual_vector_moving_average_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the dual-vector moving average
// Shared wrappers for the clocked, reset-gated concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef DUAL_VECTOR_MOVING_AVERAGE_MACROS_SVH
`define DUAL_VECTOR_MOVING_AVERAGE_MACROS_SVH

// property checked on every rising edge outside reset
`define DVMA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must never be seen outside reset
`define DVMA_ASSERT_NEVER(lbl, cond, msg) \
  `DVMA_ASSERT(lbl, !(cond), msg)

`endif

>>> sv/dvma_pkg.sv
// ----------------------------------------------------------------------------
// dvma_pkg
// Types, widths and register codes shared by the moving average modules.
// ----------------------------------------------------------------------------
package dvma_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int DATA_W     = 32;
  localparam int SUM_W      = 37;
  localparam int NUM_LANES  = 6;
  localparam int SLOT_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
  localparam int WIN_REG_W  = 6;
  localparam int WIN_CMP_W  = (CNT_W > WIN_REG_W) ? CNT_W : WIN_REG_W;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = WIN_REG_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW = CFG_IDX_W'(1);

  // register reset values
  localparam logic                 SMOOTH_RESET = 1'b1;
  localparam logic [WIN_REG_W-1:0] WIN_RESET    = WIN_REG_W'(32);

  typedef struct packed {
    logic signed [DATA_W-1:0] trans_x;
    logic signed [DATA_W-1:0] trans_y;
    logic signed [DATA_W-1:0] trans_z;
    logic signed [DATA_W-1:0] ang_x;
    logic signed [DATA_W-1:0] ang_y;
    logic signed [DATA_W-1:0] ang_z;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] avg_trans_x;
    logic signed [DATA_W-1:0] avg_trans_y;
    logic signed [DATA_W-1:0] avg_trans_z;
    logic signed [DATA_W-1:0] avg_ang_x;
    logic signed [DATA_W-1:0] avg_ang_y;
    logic signed [DATA_W-1:0] avg_ang_z;
  } out_item_t;

  // sequencer to lane controls
  typedef struct packed {
    logic              load;
    logic              update;
    logic              div_init;
    logic              div_step;
    logic              clear;
    logic              smooth;
    logic              full;
    logic [SLOT_W-1:0] addr;
    logic [CNT_W-1:0]  count;
  } lane_ctrl_t;

endpackage

>>> sv/dvma_ram.sv
// ----------------------------------------------------------------------------
// dvma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dvma_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                        wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                        rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/dvma_lane.sv
// ----------------------------------------------------------------------------
// dvma_lane
// One vector component: history ring, running sum and serial divider.
// ----------------------------------------------------------------------------
module dvma_lane import dvma_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lane_ctrl_t        ctrl_i,
  input  logic [DATA_W-1:0] sample_i,
  output logic [DATA_W-1:0] result_o
);

  localparam logic [SUM_W-1:0] POS_LIM =
    {{(SUM_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
  localparam logic [SUM_W-1:0] NEG_LIM =
    {{(SUM_W-DATA_W){1'b0}}, 1'b1, {(DATA_W-1){1'b0}}};

  logic signed [DATA_W-1:0] sample_q;
  logic [DATA_W-1:0]        old_data;
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic [SUM_W-1:0]         sample_ext, old_ext;
  logic [CNT_W-1:0]         rem_q;
  logic [CNT_W:0]           rem_sh, div_ext;
  logic [SUM_W-1:0]         quo_q;
  logic                     neg_q;
  logic                     take;
  logic [SUM_W-1:0]         q_lim;
  logic [DATA_W-1:0]        avg;

  // history ring for this component
  dvma_ram #(
    .Width (DATA_W),
    .Depth (MAX_WINDOW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ctrl_i.update),
    .waddr_i (ctrl_i.addr),
    .wdata_i (sample_q),
    .raddr_i (ctrl_i.addr),
    .rdata_o (old_data)
  );

  // sample capture at item accept
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      sample_q <= $signed(sample_i);
    end
  end

  // running sum: drop oldest once full, add newest
  assign sample_ext = SUM_W'(sample_q);
  assign old_ext    = SUM_W'($signed(old_data));

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.update && ctrl_i.smooth) begin
      sum_d = sum_q + sample_ext - (ctrl_i.full ? old_ext : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem_q, quo_q[SUM_W-1]};
  assign div_ext = {1'b0, ctrl_i.count};
  assign take    = (rem_sh >= div_ext);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_init) begin
      neg_q <= sum_q[SUM_W-1];
      quo_q <= sum_q[SUM_W-1] ? (SUM_W'(0) - sum_q) : sum_q;
      rem_q <= '0;
    end else if (ctrl_i.div_step) begin
      rem_q <= take ? CNT_W'(rem_sh - div_ext) : CNT_W'(rem_sh);
      quo_q <= {quo_q[SUM_W-2:0], take};
    end
  end

  // saturate quotient into the signed output range
  always_comb begin
    if (neg_q) begin
      q_lim = (quo_q > NEG_LIM) ? NEG_LIM : quo_q;
      avg   = DATA_W'(0) - q_lim[DATA_W-1:0];
    end else begin
      q_lim = (quo_q > POS_LIM) ? POS_LIM : quo_q;
      avg   = q_lim[DATA_W-1:0];
    end
  end

  assign result_o = ctrl_i.smooth ? avg : sample_q;

endmodule

>>> sv/dvma_ctrl.sv
// ----------------------------------------------------------------------------
// dvma_ctrl
// Sequencer: config registers, ring pointers and per-item step control.
// ----------------------------------------------------------------------------
module dvma_ctrl import dvma_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  out_free_i,
  output logic                  out_load_o,
  output lane_ctrl_t            lane_ctrl_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_UPD  = 3'd1;
  localparam logic [2:0] ST_PREP = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0]           state_q, state_d;
  logic                 smooth_q;
  logic [WIN_REG_W-1:0] win_reg_q;
  logic [CNT_W-1:0]     fill_q;
  logic [SLOT_W-1:0]    wslot_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 full_q;
  logic [STEP_W-1:0]    step_q;

  logic [WIN_CMP_W-1:0] win_ext;
  logic [CNT_W-1:0]     win;
  logic [SLOT_W-1:0]    rd_slot;
  logic                 full_now;
  logic [CNT_W-1:0]     fill_inc, slot_inc;
  logic                 in_fire, cfg_fire, win_write;

  // effective window: zero acts as one, clamp at the ring size
  assign win_ext = WIN_CMP_W'(win_reg_q);
  always_comb begin
    if (win_reg_q == '0) begin
      win = CNT_W'(1);
    end else if (win_ext > WIN_CMP_W'(MAX_WINDOW)) begin
      win = CNT_W'(MAX_WINDOW);
    end else begin
      win = CNT_W'(win_reg_q);
    end
  end

  // slot and fullness seen by the arriving item
  assign rd_slot  = (CNT_W'(wslot_q) >= win) ? '0 : wslot_q;
  assign full_now = (fill_q >= win);
  assign fill_inc = fill_q + CNT_W'(1);
  assign slot_inc = CNT_W'(slot_q) + CNT_W'(1);

  // handshakes
  assign in_ready_o  = (state_q == ST_IDLE);
  assign cfg_ready_o = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign win_write   = cfg_fire && (cfg_index_i == REG_WINDOW);
  assign out_load_o  = (state_q == ST_DONE) && out_free_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_fire) state_d = ST_UPD;
      ST_UPD:  state_d = smooth_q ? ST_PREP : ST_DONE;
      ST_PREP: state_d = ST_DIV;
      ST_DIV:  if (step_q == '0) state_d = ST_DONE;
      ST_DONE: if (out_free_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers and ring pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      smooth_q  <= SMOOTH_RESET;
      win_reg_q <= WIN_RESET;
      fill_q    <= '0;
      wslot_q   <= '0;
      slot_q    <= '0;
      full_q    <= 1'b0;
      step_q    <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_fire && (cfg_index_i == REG_SMOOTH)) begin
        smooth_q <= cfg_data_i[0];
      end
      if (win_write) begin
        win_reg_q <= cfg_data_i;
        fill_q    <= '0;
        wslot_q   <= '0;
      end
      if (in_fire) begin
        slot_q <= rd_slot;
        full_q <= full_now;
      end
      if (state_q == ST_UPD) begin
        if (!full_q) begin
          fill_q <= (fill_inc > win) ? win : fill_inc;
        end else if (fill_q > win) begin
          fill_q <= win;
        end
        wslot_q <= (slot_inc >= win) ? '0 : SLOT_W'(slot_inc);
      end
      if (state_q == ST_PREP) begin
        step_q <= STEP_W'(SUM_W - 1);
      end else if (state_q == ST_DIV) begin
        step_q <= step_q - STEP_W'(1);
      end
    end
  end

  // lane controls
  always_comb begin
    lane_ctrl_o.load     = in_fire;
    lane_ctrl_o.update   = (state_q == ST_UPD);
    lane_ctrl_o.div_init = (state_q == ST_PREP);
    lane_ctrl_o.div_step = (state_q == ST_DIV);
    lane_ctrl_o.clear    = win_write;
    lane_ctrl_o.smooth   = smooth_q;
    lane_ctrl_o.full     = full_q;
    lane_ctrl_o.addr     = (state_q == ST_IDLE) ? rd_slot : slot_q;
    lane_ctrl_o.count    = fill_q;
  end

endmodule

>>> sv/dvma_merge.sv
// ----------------------------------------------------------------------------
// dvma_merge
// Gathers the six lane results into the output item register.
// ----------------------------------------------------------------------------
module dvma_merge import dvma_pkg::*; (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              load_i,
  input  logic [NUM_LANES-1:0][DATA_W-1:0] lane_res_i,
  output logic                              out_free_o,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output out_item_t                         out_item_o
);

  logic      valid_q;
  out_item_t item_q;

  assign out_free_o = !valid_q || out_ready_i;

  // output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  // output item register
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q.avg_trans_x <= $signed(lane_res_i[0]);
      item_q.avg_trans_y <= $signed(lane_res_i[1]);
      item_q.avg_trans_z <= $signed(lane_res_i[2]);
      item_q.avg_ang_x   <= $signed(lane_res_i[3]);
      item_q.avg_ang_y   <= $signed(lane_res_i[4]);
      item_q.avg_ang_z   <= $signed(lane_res_i[5]);
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

endmodule

>>> sv/dual_vector_moving_average.sv
// ----------------------------------------------------------------------------
// dual_vector_moving_average
// Boxcar moving average over two 3-component Q16.16 vectors, six lanes.
//
//   channel  signals                                 direction
//   in       in_valid_i / in_ready_o / in_item_i     item in
//   out      out_valid_o / out_ready_i / out_item_o  item out
//   cfg      cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i  write
//
// An item with smoothing on goes from accept to result as follows: the ring
// read overlaps the accept, then one sum update, one divider load, 37 steps
// of the per-lane serial divider and the load into the output register.
// Pass-through skips the divider load and steps. The next item is taken the
// cycle after the load, so no item is accepted while another is in flight. A
// stalled output holds the sequencer in its last step.
// Reset clears sums, fill count and slot; ring contents need no clearing.
// ----------------------------------------------------------------------------
module dual_vector_moving_average import dvma_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  in_item_t              in_item_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output out_item_t             out_item_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  lane_ctrl_t                        lane_ctrl;
  logic                              out_free;
  logic                              out_load;
  logic [NUM_LANES-1:0][DATA_W-1:0] lane_in;
  logic [NUM_LANES-1:0][DATA_W-1:0] lane_res;

  // sequencer
  dvma_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_free_i  (out_free),
    .out_load_o  (out_load),
    .lane_ctrl_o (lane_ctrl)
  );

  // one lane per vector component
  assign lane_in[0] = in_item_i.trans_x;
  assign lane_in[1] = in_item_i.trans_y;
  assign lane_in[2] = in_item_i.trans_z;
  assign lane_in[3] = in_item_i.ang_x;
  assign lane_in[4] = in_item_i.ang_y;
  assign lane_in[5] = in_item_i.ang_z;

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    dvma_lane u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (lane_ctrl),
      .sample_i (lane_in[g]),
      .result_o (lane_res[g])
    );
  end

  // output register
  dvma_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (out_load),
    .lane_res_i  (lane_res),
    .out_free_o  (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

>>> sv/dvma_checker.sv
// ----------------------------------------------------------------------------
// dvma_checker
// Port-level assertions for the dual-vector moving average, bound to the top.
// ----------------------------------------------------------------------------
`include "dual_vector_moving_average_macros.svh"

module dvma_checker import dvma_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input in_item_t              in_item_i,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input out_item_t             out_item_o,
  input logic                  cfg_valid_i,
  input logic                  cfg_ready_o,
  input logic [CFG_IDX_W-1:0]  cfg_index_i,
  input logic [CFG_DATA_W-1:0] cfg_data_i
);

  logic in_fire;
  logic cfg_fire;

  assign in_fire  = in_valid_i && in_ready_o;
  assign cfg_fire = cfg_valid_i && cfg_ready_o && (cfg_index_i == REG_WINDOW) && cfg_data_i[0];

  // a waiting result holds steady
  `DVMA_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o), "output item changed while stalled")

  // one item at a time: busy right after an accept
  `DVMA_ASSERT(a_busy_after_accept, in_fire |=> !in_ready_o, "input accepted again while busy")

  // config and input readiness track the same idle condition
  `DVMA_ASSERT(a_ready_match, in_ready_o == cfg_ready_o, "config and input ready disagree")

  // a new result appears only at the end of a busy period
  `DVMA_ASSERT(a_result_after_work, $rose(out_valid_o) |-> $past(!in_ready_o), "result without work")

  // no item accepted while busy in the same cycle as a window write of odd data
  `DVMA_ASSERT_NEVER(a_cfg_in_excl, in_fire && cfg_fire && !in_ready_o, "accept while busy")

endmodule

bind dual_vector_moving_average dvma_checker u_dvma_checker (.*);
